// ----- rtl/core/pds_pkg.sv -----
// Package for the PLL divider search core: types, constants, window table.
// Used by pds_div, pds_seq and pll_divider_search_core.
package pds_pkg;

    localparam int IN_DIV_MAX_DEF  = 31;
    localparam int OUT_DIV_MAX_DEF = 3;

    localparam int NUM_W = 41;
    localparam int DEN_W = 33;

    localparam logic [31:0] REF_MIN_STEP = 32'd2000000;
    localparam logic [31:0] REF_MAX_STEP = 32'd8000000;
    localparam logic [2:0]  NUM_WIN      = 3'd7;

    localparam logic [15:0] DEFAULT_WORD = 16'hE220;
    localparam logic [1:0]  DEF_OD = 2'((DEFAULT_WORD & 16'h6000) >> 13);
    localparam logic [4:0]  DEF_NR = 5'((DEFAULT_WORD & 16'h1F00) >> 8);
    localparam logic [7:0]  DEF_FB = 8'(DEFAULT_WORD & 16'h00FF);

    typedef struct packed {
        logic        valid;
        logic [1:0]  od;
        logic [4:0]  nr;
        logic [7:0]  fb;
        logic [31:0] freq;
    } t_setting;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef enum logic [3:0] {
        S_IDLE, S_TRY, S_WAIT_B, S_CAND, S_WAIT_F, S_FOLD, S_WEND, S_OUT
    } t_state;

    function automatic logic [31:0] win_lo(input logic [2:0] w);
        case (w)
            3'd0:    win_lo = 32'd200000000;
            3'd1:    win_lo = 32'd190000000;
            3'd2:    win_lo = 32'd400000000;
            3'd3:    win_lo = 32'd180000000;
            3'd4:    win_lo = 32'd410000000;
            3'd5:    win_lo = 32'd170000000;
            default: win_lo = 32'd430000000;
        endcase
    endfunction

    function automatic logic [31:0] win_hi(input logic [2:0] w);
        case (w)
            3'd0:    win_hi = 32'd400000000;
            3'd1:    win_hi = 32'd200000001;
            3'd2:    win_hi = 32'd410000001;
            3'd3:    win_hi = 32'd190000001;
            3'd4:    win_hi = 32'd420000001;
            3'd5:    win_hi = 32'd180000001;
            default: win_hi = 32'd440000001;
        endcase
    endfunction

    function automatic logic [31:0] freq_dist(input logic [31:0] a, input logic [31:0] b);
        freq_dist = (a > b) ? a - b : b - a;
    endfunction

endpackage

// ----- rtl/core/pds_if.sv -----
// Stream interfaces for the PLL divider search core.
// Depends on nothing.
interface pds_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] ref_freq;
    logic [31:0] target_freq;
    modport source (output valid, ref_freq, target_freq, input ready);
    modport sink   (input valid, ref_freq, target_freq, output ready);
endinterface

interface pds_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_div;
    logic [4:0]  in_div;
    logic [7:0]  fb_div;
    logic [31:0] achieved_freq;
    logic        found;
    modport source (output valid, out_div, in_div, fb_div, achieved_freq, found,
                    input ready);
    modport sink   (input valid, out_div, in_div, fb_div, achieved_freq, found,
                    output ready);
endinterface

// ----- rtl/core/pds_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on pds_pkg.
module pds_div import pds_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W:0]   r_rem, n_rem;
    logic [NUM_W-1:0] r_quo, n_quo;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [DEN_W:0]   trial;
    logic             last;

    assign trial = {r_rem[DEN_W-1:0], r_quo[NUM_W-1]};
    assign last  = (r_cnt == CNT_W'(NUM_W - 1));

    always_comb begin
        if (trial >= {1'b0, r_den}) begin
            n_rem = trial - {1'b0, r_den};
            n_quo = {r_quo[NUM_W-2:0], 1'b1};
        end else begin
            n_rem = trial;
            n_quo = {r_quo[NUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.num;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_quo = r_quo;
endmodule

// ----- rtl/core/pds_seq.sv -----
// Search sequencer: sweeps windows, output and input dividers, candidates.
// Depends on pds_pkg; drives the shared divider pds_div.
module pds_seq import pds_pkg::*; #(
    parameter int IN_DIV_MAX  = IN_DIV_MAX_DEF,
    parameter int OUT_DIV_MAX = OUT_DIV_MAX_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    pds_in_if.sink           i_in,
    pds_out_if.source        o_out,
    output t_div_req         o_req,
    input  logic             i_done,
    input  logic [NUM_W-1:0] i_quo
);
    localparam logic [4:0] NR_TOP = 5'(IN_DIV_MAX);
    localparam logic [1:0] OD_TOP = 2'(OUT_DIV_MAX);

    t_state      r_state, n_state;
    logic [31:0] r_fin, n_fin, r_fout, n_fout;
    logic [2:0]  r_win, n_win;
    logic [1:0]  r_od, n_od;
    logic [4:0]  r_nr, n_nr;
    logic        r_k, n_k;
    logic [NUM_W-1:0] r_b, n_b;
    logic [7:0]  r_fb, n_fb;
    t_setting    r_t, n_t, r_best, n_best, r_res, n_res;

    logic [31:0] vco, ref_lo, ref_hi, f_new;
    logic [36:0] fout_nr;
    logic [NUM_W-1:0] cand;
    logic [8:0]  fb2;
    logic [1:0]  sh;
    t_setting    empty;

    assign empty  = '0;
    assign sh     = r_od - 2'd1;
    assign vco    = r_fout << sh;
    assign ref_lo = 32'(REF_MIN_STEP * r_nr);
    assign ref_hi = 32'(REF_MAX_STEP * r_nr);
    assign fout_nr = r_fout * r_nr;
    assign cand   = r_b + NUM_W'(r_k);
    assign fb2    = {cand[7:0], 1'b0};
    assign f_new  = (i_quo[NUM_W-1:32] != '0) ? 32'd0 : i_quo[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        r_fin <= n_fin; r_fout <= n_fout; r_win <= n_win; r_od <= n_od;
        r_nr <= n_nr; r_k <= n_k; r_b <= n_b; r_fb <= n_fb;
        r_t <= n_t; r_best <= n_best; r_res <= n_res;
    end

    always_comb begin
        n_state = r_state;
        n_fin = r_fin; n_fout = r_fout; n_win = r_win; n_od = r_od;
        n_nr = r_nr; n_k = r_k; n_b = r_b; n_fb = r_fb;
        n_t = r_t; n_best = r_best; n_res = r_res;
        o_req = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_fin  = i_in.ref_freq;
                    n_fout = i_in.target_freq;
                    n_win  = '0;
                    n_od   = OD_TOP;
                    n_nr   = NR_TOP;
                    n_best = empty;
                    n_state = S_TRY;
                end
            end
            S_TRY: begin
                n_t = empty;
                n_k = 1'b0;
                if (ref_lo < r_fin && r_fin < ref_hi &&
                    win_lo(r_win) < vco && vco < win_hi(r_win)) begin
                    o_req.start = 1'b1;
                    o_req.num   = NUM_W'({fout_nr, 2'b00} >> (2'd2 - sh));
                    o_req.den   = {r_fin, 1'b0};
                    n_state = S_WAIT_B;
                end else begin
                    n_state = S_FOLD;
                end
            end
            S_WAIT_B: begin
                if (i_done) begin
                    n_b = i_quo;
                    n_state = S_CAND;
                end
            end
            S_CAND: begin
                if (cand >= NUM_W'(1) && cand <= NUM_W'(255)) begin
                    o_req.start = 1'b1;
                    o_req.num   = NUM_W'(r_fin) * NUM_W'(fb2);
                    o_req.den   = DEN_W'({r_nr, 2'b00} >> (2'd2 - sh));
                    n_fb = cand[7:0];
                    n_state = S_WAIT_F;
                end else if (r_k) begin
                    n_state = S_FOLD;
                end else begin
                    n_k = 1'b1;
                end
            end
            S_WAIT_F: begin
                if (i_done) begin
                    if (freq_dist(f_new, r_fout) <= freq_dist(r_t.freq, r_fout)) begin
                        n_t = '{valid: 1'b1, od: r_od, nr: r_nr, fb: r_fb, freq: f_new};
                    end
                    if (r_k) begin
                        n_state = S_FOLD;
                    end else begin
                        n_k = 1'b1;
                        n_state = S_CAND;
                    end
                end
            end
            S_FOLD: begin
                // empty tries win ties too and clear the best
                if (freq_dist(r_t.freq, r_fout) <= freq_dist(r_best.freq, r_fout))
                    n_best = r_t;
                if (r_nr > 5'd1) begin
                    n_nr = r_nr - 5'd1;
                    n_state = S_TRY;
                end else if (r_od > 2'd1) begin
                    n_od = r_od - 2'd1;
                    n_nr = NR_TOP;
                    n_state = S_TRY;
                end else begin
                    n_state = S_WEND;
                end
            end
            S_WEND: begin
                if (r_best.valid) begin
                    n_res = r_best;
                    n_state = S_OUT;
                end else if (r_win == NUM_WIN - 3'd1) begin
                    n_res = '{valid: 1'b0, od: DEF_OD, nr: DEF_NR, fb: DEF_FB,
                              freq: 32'd0};
                    n_state = S_OUT;
                end else begin
                    n_win  = r_win + 3'd1;
                    n_od   = OD_TOP;
                    n_nr   = NR_TOP;
                    n_best = empty;
                    n_state = S_TRY;
                end
            end
            S_OUT: begin
                if (o_out.ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = (r_state == S_OUT);
    assign o_out.out_div       = r_res.od;
    assign o_out.in_div        = r_res.nr;
    assign o_out.fb_div        = r_res.fb;
    assign o_out.achieved_freq = r_res.freq;
    assign o_out.found         = r_res.valid;
endmodule

// ----- rtl/core/pll_divider_search_core.sv -----
// PLL divider search core. One word in, one word out; busy while searching.
// Search: a try that fails the reference or VCO test goes straight to the
// fold; a full try runs three divisions on the shared 41-bit divider plus
// the fold. Worst case 7 windows of 93 tries each.
// Throughput: one word at a time; ready only when idle.
// Reset: synchronous active-low, returns the sequencer to idle.
module pll_divider_search_core import pds_pkg::*; #(
    parameter int IN_DIV_MAX  = IN_DIV_MAX_DEF,
    parameter int OUT_DIV_MAX = OUT_DIV_MAX_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pds_in_if.sink    i_in,
    pds_out_if.source o_out
);
    t_div_req         req;
    logic             done;
    logic [NUM_W-1:0] quo;

    pds_seq #(.IN_DIV_MAX(IN_DIV_MAX), .OUT_DIV_MAX(OUT_DIV_MAX)) u_seq (
        .i_clk, .i_rst_n, .i_in, .o_out,
        .o_req(req), .i_done(done), .i_quo(quo)
    );

    pds_div u_div (
        .i_clk, .i_rst_n, .i_req(req), .o_done(done), .o_quo(quo)
    );
endmodule
